[sv/iirdf1_pkg.sv]
// Package for the direct form I IIR filter core.
// Field widths, register indexes and saturation helpers; no dependencies.
package iirdf1_pkg;

  localparam int SampleW   = 24;
  localparam int CoefW     = 32;
  localparam int HistW     = 40;
  localparam int DigitW    = 4;
  localparam int NumDigits = CoefW / DigitW;
  localparam int ProdHiW   = HistW + DigitW + 2;
  localparam int ProdLoW   = CoefW - DigitW;
  localparam int AccW      = 48;
  localparam int GainSumW  = 50;
  localparam int CfgIdxW   = 3;
  localparam int TapCntW   = 2;
  localparam int DefMaxNumTaps = 3;
  localparam int DefMaxDenTaps = 3;

  typedef enum logic [CfgIdxW-1:0] {
    RegInputGain = 3'd0,
    RegNumTaps   = 3'd1,
    RegDenTaps   = 3'd2,
    RegNumCoef0  = 3'd3,
    RegNumCoef1  = 3'd4,
    RegNumCoef2  = 3'd5,
    RegDenCoef1  = 3'd6,
    RegDenCoef2  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic start;
    logic done;
  } mul_ctrl_t;

  function automatic logic signed [HistW-1:0] sat_hist(input logic signed [GainSumW-1:0] v);
    logic signed [GainSumW-1:0] hi;
    logic signed [GainSumW-1:0] lo;
    hi = GainSumW'((64'sd1 <<< (HistW - 1)) - 64'sd1);
    lo = -hi - GainSumW'(1);
    if (v > hi) return hi[HistW-1:0];
    else if (v < lo) return lo[HistW-1:0];
    else return v[HistW-1:0];
  endfunction

  function automatic logic signed [SampleW-1:0] sat_sample(input logic signed [HistW-1:0] v);
    logic signed [HistW-1:0] hi;
    logic signed [HistW-1:0] lo;
    hi = HistW'((64'sd1 <<< (SampleW - 1)) - 64'sd1);
    lo = -hi - HistW'(1);
    if (v > hi) return hi[SampleW-1:0];
    else if (v < lo) return lo[SampleW-1:0];
    else return v[SampleW-1:0];
  endfunction

endpackage

[sv/iirdf1_mul.sv]
// Digit-serial signed multiplier, one 4-bit multiplier digit per cycle.
// Depends on iirdf1_pkg. Returns full product as hi part and 28 low bits.
module iirdf1_mul (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start_i,
  input  logic signed [iirdf1_pkg::HistW-1:0]      mcand_i,
  input  logic signed [iirdf1_pkg::CoefW-1:0]      mplier_i,
  output logic                                     done_o,
  output logic signed [iirdf1_pkg::ProdHiW-1:0]    prod_hi_o,
  output logic        [iirdf1_pkg::ProdLoW-1:0]    prod_lo_o
);

  localparam int CntW = $clog2(iirdf1_pkg::NumDigits);

  logic                                   busy_q, done_q;
  logic [CntW-1:0]                        cnt_q;
  logic signed [iirdf1_pkg::HistW-1:0]    mcand_q;
  logic [iirdf1_pkg::CoefW-1:0]           mplier_q;
  logic signed [iirdf1_pkg::ProdHiW-1:0]  hi_q;
  logic [iirdf1_pkg::ProdLoW-1:0]         lo_q;

  logic                                   last;
  logic signed [iirdf1_pkg::DigitW:0]     digit;
  logic signed [iirdf1_pkg::ProdHiW-1:0]  sum;

  assign last = (cnt_q == CntW'(iirdf1_pkg::NumDigits - 1));

  always_comb begin
    // top digit carries the sign of the multiplier
    digit = last ? {mplier_q[iirdf1_pkg::DigitW-1], mplier_q[iirdf1_pkg::DigitW-1:0]}
                 : {1'b0, mplier_q[iirdf1_pkg::DigitW-1:0]};
    sum = hi_q + iirdf1_pkg::ProdHiW'(mcand_q) * iirdf1_pkg::ProdHiW'(digit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q  <= mcand_i;
      mplier_q <= mplier_i;
      hi_q     <= '0;
      lo_q     <= '0;
    end else if (busy_q) begin
      if (last) begin
        hi_q <= sum;
      end else begin
        hi_q     <= sum >>> iirdf1_pkg::DigitW;
        lo_q     <= {sum[iirdf1_pkg::DigitW-1:0], lo_q[iirdf1_pkg::ProdLoW-1:iirdf1_pkg::DigitW]};
        mplier_q <= mplier_q >> iirdf1_pkg::DigitW;
      end
    end
  end

  assign done_o    = done_q;
  assign prod_hi_o = hi_q;
  assign prod_lo_o = lo_q;

  a_no_restart_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("multiplier restarted while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("done while still busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done held over two cycles");

endmodule

[sv/iir_filter_direct_form_one_core.sv]
// Direct form I IIR filter core, up to second order, fixed point.
// Depends on iirdf1_pkg and iirdf1_mul.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries sample_in_i and restart_i;
//   output channel (out_valid_o/out_ready_i) carries sample_out_o, one per
//   input. Registers are written through cfg_we_i/cfg_index_i/cfg_data_i;
//   the user must do so while the core is idle; the core does not enforce it.
//   Each sample runs the gain product and then up to five tap products on
//   one shared digit-serial multiplier (per product: start, eight 4-bit
//   digits of the coefficient, result). Disabled taps are skipped without
//   a product. One sample is in work at a time; the next transfer is taken
//   in the cycle after the result is registered.
//   The result sits in an output register; if the receiver stalls, the next
//   sample may be taken and computed, and the core waits in its final state
//   until the previous result is transferred.
//   Reset restores default coefficients (unity gain, pass-through) and
//   clears both histories; restart_i clears them before its sample.
module iir_filter_direct_form_one_core #(
  parameter int MAX_NUM_TAPS = iirdf1_pkg::DefMaxNumTaps,
  parameter int MAX_DEN_TAPS = iirdf1_pkg::DefMaxDenTaps
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [iirdf1_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [iirdf1_pkg::CoefW-1:0]            cfg_data_i,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [iirdf1_pkg::SampleW-1:0]   sample_in_i,
  input  logic                                    restart_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [iirdf1_pkg::SampleW-1:0]   sample_out_o
);

  localparam int HistW  = iirdf1_pkg::HistW;
  localparam int CoefW  = iirdf1_pkg::CoefW;
  localparam int AccW   = iirdf1_pkg::AccW;
  localparam int TapCntW = iirdf1_pkg::TapCntW;
  localparam int NumTaps = 5;  // three numerator plus two denominator slots
  localparam int TapW   = $clog2(NumTaps);

  typedef enum logic [2:0] {
    StIdle, StGain, StGainWait, StTap, StTapWait, StFin
  } state_e;

  state_e state_q;
  logic [TapW-1:0] tap_q;

  // configuration
  logic signed [CoefW-1:0] gain_q;
  logic [TapCntW-1:0]      num_taps_q, den_taps_q;
  logic signed [CoefW-1:0] num_coef_q [MAX_NUM_TAPS];
  logic signed [CoefW-1:0] den_coef_q [MAX_DEN_TAPS];

  logic signed [HistW-1:0] in_hist_q [2];
  logic signed [HistW-1:0] out_hist_q [2];
  logic signed [HistW-1:0] x_q;
  logic signed [AccW-1:0]  acc_q;
  logic                    out_valid_q;
  logic signed [iirdf1_pkg::SampleW-1:0] sample_out_q;

  iirdf1_pkg::mul_ctrl_t mul_ctrl;
  logic signed [HistW-1:0]              mcand;
  logic signed [CoefW-1:0]              mplier;
  logic signed [iirdf1_pkg::ProdHiW-1:0] prod_hi;
  logic [iirdf1_pkg::ProdLoW-1:0]        prod_lo;

  function automatic logic [TapCntW-1:0] eff_taps(input logic [TapCntW-1:0] v, input int maxv);
    logic [TapCntW-1:0] t;
    t = (v == '0) ? TapCntW'(1) : v;
    if (int'(t) > maxv) t = TapCntW'(maxv);
    return t;
  endfunction

  logic [TapCntW-1:0] cfg_num_eff, cfg_den_eff;
  logic               clr_cfg;
  assign cfg_num_eff = eff_taps(cfg_data_i[TapCntW-1:0], MAX_NUM_TAPS);
  assign cfg_den_eff = eff_taps(cfg_data_i[TapCntW-1:0], MAX_DEN_TAPS);
  assign clr_cfg = cfg_we_i &&
                   ((cfg_index_i == iirdf1_pkg::RegNumTaps && cfg_num_eff != num_taps_q) ||
                    (cfg_index_i == iirdf1_pkg::RegDenTaps && cfg_den_eff != den_taps_q));

  logic in_xfer, fin_go;
  assign in_ready_o = (state_q == StIdle);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign fin_go     = (state_q == StFin) && (!out_valid_q || out_ready_i);

  // tap enable and operand selection
  logic tap_en, tap_sub;
  always_comb begin
    tap_en  = 1'b0;
    tap_sub = 1'b0;
    mcand   = x_q;
    mplier  = '0;
    unique case (tap_q)
      TapW'(0): begin tap_en = 1'b1; mcand = x_q; end
      TapW'(1): begin tap_en = (num_taps_q > TapCntW'(1)); mcand = in_hist_q[0]; end
      TapW'(2): begin tap_en = (num_taps_q > TapCntW'(2)); mcand = in_hist_q[1]; end
      TapW'(3): begin
        tap_en = (den_taps_q > TapCntW'(1)); tap_sub = 1'b1; mcand = out_hist_q[0];
      end
      TapW'(4): begin
        tap_en = (den_taps_q > TapCntW'(2)); tap_sub = 1'b1; mcand = out_hist_q[1];
      end
      default: ;
    endcase
    for (int k = 0; k < MAX_NUM_TAPS; k++)
      if (int'(tap_q) == k) mplier = num_coef_q[k];
    for (int k = 1; k < MAX_DEN_TAPS; k++)
      if (int'(tap_q) == k + 2) mplier = den_coef_q[k];
    if (state_q == StGain) begin
      mcand  = {{(HistW-iirdf1_pkg::SampleW){x_q[iirdf1_pkg::SampleW-1]}},
                x_q[iirdf1_pkg::SampleW-1:0]};
      mplier = gain_q;
    end
  end

  assign mul_ctrl.start = (state_q == StGain) || (state_q == StTap && tap_en);

  iirdf1_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_ctrl.start),
    .mcand_i   (mcand),
    .mplier_i  (mplier),
    .done_o    (mul_ctrl.done),
    .prod_hi_o (prod_hi),
    .prod_lo_o (prod_lo)
  );

  // gain result: (P + 2^7) >>> 8; tap result: (P + 2^27) >>> 28
  logic signed [iirdf1_pkg::GainSumW-1:0] gain_sum;
  logic signed [AccW-1:0]                 tap_prod, acc_next;
  logic signed [HistW-1:0]                acc_sat;
  logic signed [HistW-1:0]                y_round;
  assign gain_sum = $signed({prod_hi[iirdf1_pkg::GainSumW-21:0], prod_lo[27:8]})
                    + iirdf1_pkg::GainSumW'(prod_lo[7]);
  assign tap_prod = AccW'(prod_hi) + AccW'(prod_lo[27]);
  assign acc_next = tap_sub ? acc_q - tap_prod : acc_q + tap_prod;
  assign acc_sat  = iirdf1_pkg::sat_hist(iirdf1_pkg::GainSumW'(acc_q));
  assign y_round  = HistW'((iirdf1_pkg::GainSumW'(acc_sat) + iirdf1_pkg::GainSumW'(32768))
                           >>> 16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      tap_q       <= '0;
      out_valid_q <= 1'b0;
      gain_q      <= CoefW'(32'sd16777216);
      num_taps_q  <= TapCntW'(1);
      den_taps_q  <= TapCntW'(1);
      num_coef_q[0] <= CoefW'(32'sd268435456);
      for (int k = 1; k < MAX_NUM_TAPS; k++) num_coef_q[k] <= '0;
      for (int k = 0; k < MAX_DEN_TAPS; k++) den_coef_q[k] <= '0;
      for (int k = 0; k < 2; k++) begin
        in_hist_q[k]  <= '0;
        out_hist_q[k] <= '0;
      end
    end else begin
      if (out_valid_q && out_ready_i && !fin_go) out_valid_q <= 1'b0;

      if (cfg_we_i) begin
        unique case (cfg_index_i)
          iirdf1_pkg::RegInputGain: gain_q <= cfg_data_i;
          iirdf1_pkg::RegNumTaps:   num_taps_q <= cfg_num_eff;
          iirdf1_pkg::RegDenTaps:   den_taps_q <= cfg_den_eff;
          iirdf1_pkg::RegNumCoef0, iirdf1_pkg::RegNumCoef1, iirdf1_pkg::RegNumCoef2: begin
            for (int k = 0; k < MAX_NUM_TAPS; k++)
              if (int'(cfg_index_i) - int'(iirdf1_pkg::RegNumCoef0) == k)
                num_coef_q[k] <= cfg_data_i;
          end
          iirdf1_pkg::RegDenCoef1, iirdf1_pkg::RegDenCoef2: begin
            for (int k = 1; k < MAX_DEN_TAPS; k++)
              if (int'(cfg_index_i) - int'(iirdf1_pkg::RegDenCoef1) + 1 == k)
                den_coef_q[k] <= cfg_data_i;
          end
          default: ;
        endcase
      end

      if (clr_cfg || (in_xfer && restart_i)) begin
        for (int k = 0; k < 2; k++) begin
          in_hist_q[k]  <= '0;
          out_hist_q[k] <= '0;
        end
      end

      unique case (state_q)
        StIdle: if (in_xfer) state_q <= StGain;
        StGain: state_q <= StGainWait;
        StGainWait: if (mul_ctrl.done) begin
          tap_q   <= '0;
          state_q <= StTap;
        end
        StTap: begin
          if (tap_en) state_q <= StTapWait;
          else if (tap_q == TapW'(NumTaps - 1)) state_q <= StFin;
          else tap_q <= tap_q + TapW'(1);
        end
        StTapWait: if (mul_ctrl.done) begin
          if (tap_q == TapW'(NumTaps - 1)) state_q <= StFin;
          else begin
            tap_q   <= tap_q + TapW'(1);
            state_q <= StTap;
          end
        end
        StFin: if (fin_go) begin
          out_valid_q   <= 1'b1;
          in_hist_q[1]  <= in_hist_q[0];
          in_hist_q[0]  <= x_q;
          out_hist_q[1] <= out_hist_q[0];
          out_hist_q[0] <= acc_sat;
          state_q       <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer)
      x_q <= HistW'(sample_in_i);
    else if (state_q == StGainWait && mul_ctrl.done)
      x_q <= iirdf1_pkg::sat_hist(gain_sum);
    if (state_q == StGainWait && mul_ctrl.done)
      acc_q <= '0;
    else if (state_q == StTapWait && mul_ctrl.done)
      acc_q <= acc_next;
    if (fin_go)
      sample_out_q <= iirdf1_pkg::sat_sample(y_round);
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_ctrl.done |-> (state_q == StGainWait || state_q == StTapWait))
    else $error("multiplier result outside a wait state");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q)
    else $error("pending result dropped");
  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFin && out_valid_q && !out_ready_i) |=> state_q == StFin)
    else $error("result computed over a stalled one");

endmodule

[verif/tb.sv]
// Testbench for iir_filter_direct_form_one_core: random and directed samples,
// with a bit-accurate fixed-point filter model. Depends on iirdf1_pkg.
module tb;

  localparam int CycleLimit = 1500000;
  localparam int HoldAt     = 20000;
  localparam int HoldLen    = 500;

  typedef struct {
    logic signed [iirdf1_pkg::SampleW-1:0] smp;
    logic                                  rst;
  } smp_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [iirdf1_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [iirdf1_pkg::CoefW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [iirdf1_pkg::SampleW-1:0] sample_in = '0;
  logic restart_in = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [iirdf1_pkg::SampleW-1:0] sample_out;

  smp_item_t pending_q[$];
  logic signed [iirdf1_pkg::SampleW-1:0] filtered_q[$];
  int errors = 0;
  int cycles = 0;
  int tx_gap = 0;
  int rx_gap = 0;
  bit tx_quiet = 0;
  bit rx_quiet = 0;
  logic nv, nr;
  smp_item_t cur;

  // filter model state
  logic signed [31:0] m_gain;
  int unsigned        m_ntaps, m_dtaps;
  logic signed [31:0] m_num [3];
  logic signed [31:0] m_den [3];
  logic signed [39:0] m_xh [2];
  logic signed [39:0] m_yh [2];

  iir_filter_direct_form_one_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .sample_in_i (sample_in),
    .restart_i   (restart_in),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .sample_out_o(sample_out)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic signed [79:0] sat_to(input logic signed [79:0] v, input int w);
    logic signed [79:0] hi;
    logic signed [79:0] lo;
    hi = (80'sd1 <<< (w - 1)) - 80'sd1;
    lo = -hi - 80'sd1;
    if (v > hi) return hi;
    else if (v < lo) return lo;
    return v;
  endfunction

  // round(h * c / 2^28), add half then floor
  function automatic logic signed [79:0] tap_prod(input logic signed [39:0] h,
                                                  input logic signed [31:0] c);
    logic signed [79:0] p;
    p = 80'(h);
    p = p * c;
    return (p + 80'sd134217728) >>> 28;
  endfunction

  function automatic int unsigned tap_count(input logic [iirdf1_pkg::CoefW-1:0] v,
                                            input int unsigned mx);
    int unsigned t;
    t = 32'(v[1:0]);
    if (t == 0) t = 1;
    if (t > mx) t = mx;
    return t;
  endfunction

  function automatic void clear_hist();
    m_xh[0] = '0; m_xh[1] = '0;
    m_yh[0] = '0; m_yh[1] = '0;
  endfunction

  function automatic void model_reset();
    m_gain = 32'sd16777216;
    m_ntaps = 1;
    m_dtaps = 1;
    m_num[0] = 32'sd268435456; m_num[1] = '0; m_num[2] = '0;
    m_den[0] = '0; m_den[1] = '0; m_den[2] = '0;
    clear_hist();
  endfunction

  function automatic logic signed [iirdf1_pkg::SampleW-1:0] filt_step(
      input logic signed [iirdf1_pkg::SampleW-1:0] s, input logic r);
    logic signed [79:0] p;
    logic signed [79:0] acc;
    logic signed [79:0] t;
    logic signed [39:0] x;
    if (r) clear_hist();
    p = 80'(s);
    p = p * m_gain;
    t = sat_to((p + 80'sd128) >>> 8, 40);
    x = t[39:0];
    acc = tap_prod(x, m_num[0]);
    for (int i = 1; i < m_ntaps; i++) acc = acc + tap_prod(m_xh[i-1], m_num[i]);
    for (int i = 1; i < m_dtaps; i++) acc = acc - tap_prod(m_yh[i-1], m_den[i]);
    acc = sat_to(acc, 40);
    m_xh[1] = m_xh[0];
    m_xh[0] = x;
    m_yh[1] = m_yh[0];
    m_yh[0] = acc[39:0];
    t = sat_to((acc + 80'sd32768) >>> 16, 24);
    return t[iirdf1_pkg::SampleW-1:0];
  endfunction

  task automatic cfg_write(input iirdf1_pkg::cfg_reg_e idx,
                           input logic [iirdf1_pkg::CoefW-1:0] val);
    int unsigned t;
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      iirdf1_pkg::RegInputGain: m_gain = val;
      iirdf1_pkg::RegNumTaps: begin
        t = tap_count(val, 3);
        if (t != m_ntaps) clear_hist();
        m_ntaps = t;
      end
      iirdf1_pkg::RegDenTaps: begin
        t = tap_count(val, 3);
        if (t != m_dtaps) clear_hist();
        m_dtaps = t;
      end
      iirdf1_pkg::RegNumCoef0: m_num[0] = val;
      iirdf1_pkg::RegNumCoef1: m_num[1] = val;
      iirdf1_pkg::RegNumCoef2: m_num[2] = val;
      iirdf1_pkg::RegDenCoef1: m_den[1] = val;
      iirdf1_pkg::RegDenCoef2: m_den[2] = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic push_smp(input logic signed [iirdf1_pkg::SampleW-1:0] s, input logic r);
    smp_item_t it;
    it.smp = s;
    it.rst = r;
    pending_q.push_back(it);
  endtask

  // sender pauses here until every result is back; checked between edges
  task automatic drain();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || in_valid || filtered_q.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [iirdf1_pkg::CoefW-1:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom();
      default: return $signed($urandom_range(0, 32'h1FFFFFFF)) - 32'sh10000000;
    endcase
  endfunction

  function automatic logic signed [iirdf1_pkg::SampleW-1:0] rand_smp();
    case ($urandom_range(0, 9))
      0: return 24'sh7FFFFF;
      1: return -24'sh800000;
      default: return iirdf1_pkg::SampleW'($urandom());
    endcase
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      nv = in_valid;
      if (in_valid && in_ready) begin
        filtered_q.push_back(filt_step(sample_in, restart_in));
        nv = 1'b0;
      end
      if (!nv) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_q.size() > 0) begin
          cur = pending_q.pop_front();
          sample_in <= cur.smp;
          restart_in <= cur.rst;
          nv = 1'b1;
          tx_gap = tx_quiet ? 0 : $urandom_range(0, 16);
        end
      end
      in_valid <= nv;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles++;
      if (out_valid && out_ready) begin
        if (filtered_q.size() == 0) begin
          $error("sample_out: unexpected transfer, got %0d", sample_out);
          errors++;
        end else begin
          if (sample_out !== filtered_q[0]) begin
            $error("sample_out: expected %0d, got %0d", filtered_q[0], sample_out);
            errors++;
          end
          void'(filtered_q.pop_front());
        end
        rx_gap = rx_quiet ? 0 : $urandom_range(0, 16);
      end
      if (cycles >= HoldAt && cycles < HoldAt + HoldLen) begin
        nr = 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        nr = 1'b0;
      end else begin
        nr = 1'b1;
      end
      out_ready <= nr;
      if (cycles > CycleLimit) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  initial begin
    model_reset();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // defaults: pass-through, sample extremes and restart
    push_smp(24'sh7FFFFF, 1'b0);
    push_smp(-24'sh800000, 1'b0);
    push_smp(24'sd0, 1'b1);
    push_smp(24'sd1, 1'b0);
    push_smp(-24'sd1, 1'b0);
    drain();

    // full order, largest gain and coefficients: saturation everywhere
    cfg_write(iirdf1_pkg::RegNumTaps, 32'd3);
    cfg_write(iirdf1_pkg::RegDenTaps, 32'd3);
    cfg_write(iirdf1_pkg::RegInputGain, 32'h7FFFFFFF);
    cfg_write(iirdf1_pkg::RegNumCoef0, 32'h7FFFFFFF);
    cfg_write(iirdf1_pkg::RegNumCoef1, 32'h7FFFFFFF);
    cfg_write(iirdf1_pkg::RegNumCoef2, 32'h80000000);
    cfg_write(iirdf1_pkg::RegDenCoef1, 32'h80000000);
    cfg_write(iirdf1_pkg::RegDenCoef2, 32'h7FFFFFFF);
    push_smp(24'sh7FFFFF, 1'b0);
    push_smp(24'sh7FFFFF, 1'b0);
    push_smp(-24'sh800000, 1'b0);
    push_smp(24'sd5, 1'b1);
    push_smp(-24'sh800000, 1'b0);
    drain();

    // most negative gain; equal tap write keeps history, zero count means one
    cfg_write(iirdf1_pkg::RegInputGain, 32'h80000000);
    cfg_write(iirdf1_pkg::RegNumTaps, 32'd3);
    push_smp(-24'sh800000, 1'b0);
    push_smp(24'sh7FFFFF, 1'b0);
    drain();
    cfg_write(iirdf1_pkg::RegDenTaps, 32'd0);
    cfg_write(iirdf1_pkg::RegInputGain, 32'h00800000);
    cfg_write(iirdf1_pkg::RegNumCoef0, 32'h10000000);
    cfg_write(iirdf1_pkg::RegNumCoef1, 32'hF0000000);
    push_smp(24'sd1000, 1'b0);
    push_smp(-24'sd3, 1'b0);
    push_smp(24'sd7, 1'b0);
    drain();
    cfg_write(iirdf1_pkg::RegNumTaps, 32'd2);
    cfg_write(iirdf1_pkg::RegDenTaps, 32'd2);
    cfg_write(iirdf1_pkg::RegDenCoef1, 32'h08000000);
    push_smp(24'sd12345, 1'b0);
    push_smp(-24'sd54321, 1'b0);
    push_smp(24'sd1, 1'b1);
    push_smp(24'sd2, 1'b0);
    drain();

    // random phases
    for (int ph = 0; ph < 10; ph++) begin
      tx_quiet = (ph % 4 == 1);
      rx_quiet = (ph % 4 == 2);
      for (int k = 0; k < 8; k++) begin
        case ($urandom_range(0, 7))
          0: cfg_write(iirdf1_pkg::RegInputGain,
                       (ph % 3 == 0) ? rand_coef() : 32'h01000000);
          1: cfg_write(iirdf1_pkg::RegNumTaps, $urandom_range(0, 3));
          2: cfg_write(iirdf1_pkg::RegDenTaps, $urandom_range(0, 3));
          3: cfg_write(iirdf1_pkg::RegNumCoef0, rand_coef());
          4: cfg_write(iirdf1_pkg::RegNumCoef1, rand_coef());
          5: cfg_write(iirdf1_pkg::RegNumCoef2, rand_coef());
          6: cfg_write(iirdf1_pkg::RegDenCoef1, rand_coef());
          default: cfg_write(iirdf1_pkg::RegDenCoef2, rand_coef());
        endcase
      end
      for (int n = 0; n < 160; n++) push_smp(rand_smp(), $urandom_range(0, 19) == 0);
      drain();
    end

    repeat (80) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

[iir_filter_direct_form_one_core.f]
sv/iirdf1_pkg.sv
sv/iirdf1_mul.sv
sv/iir_filter_direct_form_one_core.sv
verif/tb.sv
